### sv/drf_pkg.sv
// Shared tables and helper functions for the DES round function block.
`default_nettype none

package drf_pkg;

  // Field widths of the words on the two channels, and the number of S-boxes.
  localparam int unsigned HalfW = 32;
  localparam int unsigned KeyW  = 48;
  localparam int unsigned NumSbox = 8;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [5:0]       tab_pos_t;
  typedef logic [3:0]       nibble_t;

  // Expansion table, bit 1 is the most significant bit of the right half.
  localparam tab_pos_t E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  // Output permutation table, same bit numbering.
  localparam tab_pos_t P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // The eight S-boxes, each entry addressed by {row, column}.
  localparam nibble_t SBOX [8][64] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  // Turn a table position (1 = MSB) of a 32-bit word into a bit index.
  function automatic logic [4:0] msb_pos(input tab_pos_t pos);
    logic [5:0] idx;
    idx = 6'd32 - pos;
    return idx[4:0];
  endfunction

  // Expand the right half to 48 bits with the E table.
  function automatic key_t expand(input half_t r);
    key_t e;
    e = '0;
    for (int i = 0; i < 48; i++) begin
      e[47-i] = r[msb_pos(E_TAB[i])];
    end
    return e;
  endfunction

  // Permute the S-box word with the P table.
  function automatic half_t permute(input half_t s);
    half_t p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      p[31-i] = s[msb_pos(P_TAB[i])];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/drf_if.sv
// Valid/ready channel interfaces for the round function input and result words.
`default_nettype none

interface drf_in_if;
  logic          valid;
  logic          ready;
  drf_pkg::half_t right_half;
  drf_pkg::key_t  round_subkey;

  modport source (output valid, output right_half, output round_subkey, input ready);
  modport sink   (input valid, input right_half, input round_subkey, output ready);
endinterface

interface drf_out_if;
  logic          valid;
  logic          ready;
  drf_pkg::half_t f_result;

  modport source (output valid, output f_result, input ready);
  modport sink   (input valid, input f_result, output ready);
endinterface

`default_nettype wire

### sv/drf_expand.sv
// Expansion of the right half and mixing with the round subkey.
`default_nettype none

module drf_expand (
  input  wire drf_pkg::half_t right_half,
  input  wire drf_pkg::key_t  round_subkey,
  output drf_pkg::key_t       mixed
);

  // Expand to 48 bits, then XOR in the subkey.
  assign mixed = drf_pkg::expand(right_half) ^ round_subkey;

endmodule

`default_nettype wire

### sv/drf_subst.sv
// S-box substitution of the mixed word followed by the P permutation.
`default_nettype none

module drf_subst (
  input  wire drf_pkg::key_t  mixed,
  output drf_pkg::half_t      f_value
);

  drf_pkg::half_t sbox_word;

  // Each 6-bit group picks row from its outer bits, column from its inner bits.
  always_comb begin
    logic [5:0] six;
    sbox_word = '0;
    for (int b = 0; b < drf_pkg::NumSbox; b++) begin
      six = mixed[47-6*b -: 6];
      sbox_word[31-4*b -: 4] = drf_pkg::SBOX[b][{six[5], six[0], six[4:1]}];
    end
  end

  // Final bit permutation.
  assign f_value = drf_pkg::permute(sbox_word);

endmodule

`default_nettype wire

### sv/des_round_function.sv
// Top level of the DES Feistel round function with input and result registers.
//
//   channel | direction | word contents
//   in_if   | sink      | right_half[31:0], round_subkey[47:0]
//   out_if  | source    | f_result[31:0]
//
// Each word passes an input register, the expansion, S-box and permutation logic,
// and a result register, from which its result is offered on out_if.
// One word is accepted per cycle while out_if takes results; in_if.ready is high
// when the input register is empty or its word moves on to the result register.
// With both registers full and out_if stalled, in_if stalls until a result leaves.
// Reset clears only the two stage valid flags.
`default_nettype none

module des_round_function (
  input  wire            clk,
  input  wire            rst_n,
  drf_in_if.sink         in_if,
  drf_out_if.source      out_if
);

  // Input stage registers.
  logic           in_vld_r;
  drf_pkg::half_t right_half_r;
  drf_pkg::key_t  round_subkey_r;

  // Result stage registers.
  logic           out_vld_r;
  drf_pkg::half_t f_result_r;

  drf_pkg::key_t  mixed;
  drf_pkg::half_t f_value;
  logic           out_free;
  logic           in_free;

  // A stage can load when it is empty or its word leaves this cycle.
  assign out_free    = !out_vld_r || out_if.ready;
  assign in_free     = !in_vld_r || out_free;
  assign in_if.ready = in_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_free) begin
      in_vld_r <= in_if.valid;
    end
    if (in_free && in_if.valid) begin
      right_half_r   <= in_if.right_half;
      round_subkey_r <= in_if.round_subkey;
    end
  end

  drf_expand u_expand (
    .right_half   (right_half_r),
    .round_subkey (round_subkey_r),
    .mixed        (mixed)
  );

  drf_subst u_subst (
    .mixed   (mixed),
    .f_value (f_value)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (out_free && in_vld_r) begin
      f_result_r <= f_value;
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.f_result = f_result_r;

endmodule

`default_nettype wire
